@@ src/complex_arithmetic_unit_defines.svh @@
// Assertion helpers used by the top-level file of this block.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define CAU_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define CAU_ASSERT_NEXT(lbl, clk, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/cau_pkg.sv @@
`timescale 1ns / 1ps
package cau_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_CONJ  = 3'd4;
  localparam logic [2:0] OP_MOD   = 3'd5;
  localparam logic [2:0] OP_SCALE = 3'd6;
  localparam logic [2:0] OP_DIVR  = 3'd7;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // Per-transaction control that rides along the divider chain.
  typedef struct packed {
    logic is_div;
    logic div_zero;
    logic eq;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } cau_ctrl_t;

endpackage

@@ src/cau_front.sv @@
`timescale 1ns / 1ps
module cau_front #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [2:0]                in_opcode,
  input  logic signed [W-1:0]       in_a_re,
  input  logic signed [W-1:0]       in_a_im,
  input  logic signed [W-1:0]       in_b_re,
  input  logic signed [W-1:0]       in_b_im,
  output logic                      f_valid,
  output cau_pkg::cau_ctrl_t        f_ctrl,
  output logic signed [2*W+1:0]     f_sre,
  output logic signed [2*W+1:0]     f_sim,
  output logic [2*W+F-1:0]          f_un_re,
  output logic [2*W+F-1:0]          f_un_im,
  output logic [2*W-1:0]            f_den
);
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int RW = 2 * W + 2;
  localparam int UW = 2 * W + F;

  // stage 1: products
  logic signed [W-1:0]  m0a, m0b, m1a, m1b;
  logic                 v1_r;
  logic [2:0]           op1_r;
  logic signed [W-1:0]  ar1_r, ai1_r, br1_r, bi1_r;
  logic                 eq1_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;

  always_comb begin
    if (in_opcode == cau_pkg::OP_MOD) begin
      m0a = in_a_re; m0b = in_a_re; m1a = in_a_im; m1b = in_a_im;
    end else begin
      m0a = in_a_re; m0b = in_b_re; m1a = in_a_im; m1b = in_b_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      op1_r <= in_opcode;
      ar1_r <= in_a_re;
      ai1_r <= in_a_im;
      br1_r <= in_b_re;
      bi1_r <= in_b_im;
      eq1_r <= (in_a_re == in_b_re) && (in_a_im == in_b_im);
      p0_r  <= m0a * m0b;
      p1_r  <= m1a * m1b;
      p2_r  <= in_a_re * in_b_im;
      p3_r  <= in_a_im * in_b_re;
      p4_r  <= in_b_re * in_b_re;
      p5_r  <= in_b_im * in_b_im;
    end
  end

  // stage 2: sums, simple results, divisor
  logic signed [SW-1:0] e0, e1, e2, e3, t0, t1;
  logic signed [W:0]    w0, w1;
  logic signed [RW-1:0] sre_nxt, sim_nxt;
  logic signed [SW-1:0] nre_nxt, nim_nxt;
  logic [PW-1:0]        den_nxt;
  logic [W-1:0]         brmag;
  logic                 div_nxt, dneg_nxt;

  assign e0 = SW'(p0_r);
  assign e1 = SW'(p1_r);
  assign e2 = SW'(p2_r);
  assign e3 = SW'(p3_r);
  assign brmag = br1_r[W-1] ? (~br1_r + 1'b1) : br1_r;

  always_comb begin
    sre_nxt  = '0;
    sim_nxt  = '0;
    nre_nxt  = '0;
    nim_nxt  = '0;
    den_nxt  = '0;
    div_nxt  = 1'b0;
    dneg_nxt = 1'b0;
    w0 = '0;
    w1 = '0;
    t0 = '0;
    t1 = '0;
    case (op1_r)
      cau_pkg::OP_ADD: begin
        w0 = (W+1)'(ar1_r) + (W+1)'(br1_r);
        w1 = (W+1)'(ai1_r) + (W+1)'(bi1_r);
        sre_nxt = RW'(w0);
        sim_nxt = RW'(w1);
      end
      cau_pkg::OP_SUB: begin
        w0 = (W+1)'(ar1_r) - (W+1)'(br1_r);
        w1 = (W+1)'(ai1_r) - (W+1)'(bi1_r);
        sre_nxt = RW'(w0);
        sim_nxt = RW'(w1);
      end
      cau_pkg::OP_MUL: begin
        t0 = e0 - e1;
        t1 = e2 + e3;
        sre_nxt = RW'(t0 >>> F);
        sim_nxt = RW'(t1 >>> F);
      end
      cau_pkg::OP_DIV: begin
        nre_nxt = e0 + e1;
        nim_nxt = e3 - e2;
        den_nxt = p4_r + p5_r;
        div_nxt = 1'b1;
      end
      cau_pkg::OP_CONJ: begin
        sre_nxt = RW'(ar1_r);
        sim_nxt = -RW'(ai1_r);
      end
      cau_pkg::OP_MOD: begin
        t0 = e0 + e1;
        sre_nxt = RW'(t0 >>> F);
      end
      cau_pkg::OP_SCALE: begin
        sre_nxt = RW'(p0_r >>> F);
        sim_nxt = RW'(p3_r >>> F);
      end
      default: begin
        nre_nxt  = SW'(ar1_r);
        nim_nxt  = SW'(ai1_r);
        den_nxt  = PW'(brmag);
        dneg_nxt = br1_r[W-1];
        div_nxt  = 1'b1;
      end
    endcase
  end

  logic                 v2_r, eq2_r, div2_r, dneg2_r;
  logic signed [RW-1:0] sre2_r, sim2_r;
  logic signed [SW-1:0] nre2_r, nim2_r;
  logic [PW-1:0]        den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      eq2_r   <= eq1_r;
      div2_r  <= div_nxt;
      dneg2_r <= dneg_nxt;
      sre2_r  <= sre_nxt;
      sim2_r  <= sim_nxt;
      nre2_r  <= nre_nxt;
      nim2_r  <= nim_nxt;
      den2_r  <= den_nxt;
    end
  end

  // stage 3: magnitudes, shift, quotient range check
  logic [SW-1:0]      mre, mim;
  logic [UW-1:0]      un_re_nxt, un_im_nxt;
  cau_pkg::cau_ctrl_t ctrl_nxt;

  assign mre = nre2_r[SW-1] ? -nre2_r : nre2_r;
  assign mim = nim2_r[SW-1] ? -nim2_r : nim2_r;
  assign un_re_nxt = UW'(mre[PW-1:0]) << F;
  assign un_im_nxt = UW'(mim[PW-1:0]) << F;

  always_comb begin
    ctrl_nxt.is_div   = div2_r;
    ctrl_nxt.div_zero = div2_r && (den2_r == '0);
    ctrl_nxt.eq       = eq2_r;
    ctrl_nxt.neg_re   = nre2_r[SW-1] ^ dneg2_r;
    ctrl_nxt.neg_im   = nim2_r[SW-1] ^ dneg2_r;
    ctrl_nxt.ovf_re   = (un_re_nxt >> W) >= UW'(den2_r);
    ctrl_nxt.ovf_im   = (un_im_nxt >> W) >= UW'(den2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= v2_r;
    end
    if (adv) begin
      f_ctrl  <= ctrl_nxt;
      f_sre   <= sre2_r;
      f_sim   <= sim2_r;
      f_un_re <= un_re_nxt;
      f_un_im <= un_im_nxt;
      f_den   <= den2_r;
    end
  end

endmodule

@@ src/cau_div_stage.sv @@
`timescale 1ns / 1ps
module cau_div_stage #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  d_valid,
  input  cau_pkg::cau_ctrl_t    d_ctrl,
  input  logic signed [2*W+1:0] d_sre,
  input  logic signed [2*W+1:0] d_sim,
  input  logic [2*W+F-1:0]      d_r_re,
  input  logic [2*W+F-1:0]      d_r_im,
  input  logic [2*W-1:0]        d_den,
  input  logic [W-1:0]          d_q_re,
  input  logic [W-1:0]          d_q_im,
  output logic                  q_valid,
  output cau_pkg::cau_ctrl_t    q_ctrl,
  output logic signed [2*W+1:0] q_sre,
  output logic signed [2*W+1:0] q_sim,
  output logic [2*W+F-1:0]      q_r_re,
  output logic [2*W+F-1:0]      q_r_im,
  output logic [2*W-1:0]        q_den,
  output logic [W-1:0]          q_q_re,
  output logic [W-1:0]          q_q_im
);
  localparam int UW = 2 * W + F;

  logic [UW-1:0] dsh;
  logic          fit_re, fit_im;
  logic [W-1:0]  qre_nxt, qim_nxt;

  // restoring step: one quotient bit per lane
  assign dsh    = UW'(d_den) << BIT;
  assign fit_re = (d_r_re >> BIT) >= UW'(d_den);
  assign fit_im = (d_r_im >> BIT) >= UW'(d_den);

  always_comb begin
    qre_nxt = d_q_re;
    qim_nxt = d_q_im;
    qre_nxt[BIT] = fit_re;
    qim_nxt[BIT] = fit_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid <= 1'b0;
    end else if (adv) begin
      q_valid <= d_valid;
    end
    if (adv) begin
      q_ctrl <= d_ctrl;
      q_sre  <= d_sre;
      q_sim  <= d_sim;
      q_r_re <= fit_re ? d_r_re - dsh : d_r_re;
      q_r_im <= fit_im ? d_r_im - dsh : d_r_im;
      q_den  <= d_den;
      q_q_re <= qre_nxt;
      q_q_im <= qim_nxt;
    end
  end

endmodule

@@ src/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_opcode, in_a_re, in_a_im, in_b_re, in_b_im
// out_      output     out_valid/out_stall out_res_re, out_res_im, out_operands_equal,
//                                          out_status
//
// One transaction is taken per cycle while in_stall is low; each result passes through the
// front end, the quotient chain, which resolves one quotient bit per stage, and the output register.
// Reset (rst_n low at a clock edge) empties every stage; no clearing pass is needed.
// A stall at the output while out_valid is high freezes the whole pipeline in place, and in_stall is raised
// in the same cycle, so no transaction is dropped or repeated.
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_operands_equal,
  output logic [1:0]                   out_status
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int RW = 2 * W + 2;
  localparam int UW = 2 * W + F;

  // Advance every stage together unless a finished result is held at the output.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Quotient chain taps: tap 0 is the front end, tap W the last divider stage.
  logic                 ch_valid [W+1];
  cau_pkg::cau_ctrl_t   ch_ctrl  [W+1];
  logic signed [RW-1:0] ch_sre   [W+1];
  logic signed [RW-1:0] ch_sim   [W+1];
  logic [UW-1:0]        ch_r_re  [W+1];
  logic [UW-1:0]        ch_r_im  [W+1];
  logic [PW-1:0]        ch_den   [W+1];
  logic [W-1:0]         ch_q_re  [W+1];
  logic [W-1:0]         ch_q_im  [W+1];

  // Front end: products, sums, simple results and divider set-up over three stages.
  cau_front #(.W(W), .F(F)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_a_re   (in_a_re),
    .in_a_im   (in_a_im),
    .in_b_re   (in_b_re),
    .in_b_im   (in_b_im),
    .f_valid   (ch_valid[0]),
    .f_ctrl    (ch_ctrl[0]),
    .f_sre     (ch_sre[0]),
    .f_sim     (ch_sim[0]),
    .f_un_re   (ch_r_re[0]),
    .f_un_im   (ch_r_im[0]),
    .f_den     (ch_den[0])
  );

  assign ch_q_re[0] = '0;
  assign ch_q_im[0] = '0;

  // Quotient chain, most significant bit first. Non-divide results ride along.
  for (genvar k = 0; k < W; k++) begin : g_div
    cau_div_stage #(.W(W), .F(F), .BIT(W - 1 - k)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .d_valid (ch_valid[k]),
      .d_ctrl  (ch_ctrl[k]),
      .d_sre   (ch_sre[k]),
      .d_sim   (ch_sim[k]),
      .d_r_re  (ch_r_re[k]),
      .d_r_im  (ch_r_im[k]),
      .d_den   (ch_den[k]),
      .d_q_re  (ch_q_re[k]),
      .d_q_im  (ch_q_im[k]),
      .q_valid (ch_valid[k+1]),
      .q_ctrl  (ch_ctrl[k+1]),
      .q_sre   (ch_sre[k+1]),
      .q_sim   (ch_sim[k+1]),
      .q_r_re  (ch_r_re[k+1]),
      .q_r_im  (ch_r_im[k+1]),
      .q_den   (ch_den[k+1]),
      .q_q_re  (ch_q_re[k+1]),
      .q_q_im  (ch_q_im[k+1])
    );
  end

  // Output stage: apply the quotient sign, pick the result, clamp to the word.
  localparam logic signed [RW-1:0] HI_LIM = RW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [RW-1:0] LO_LIM = ~HI_LIM;
  localparam logic signed [RW-1:0] BIG    = RW'(1) << W;

  cau_pkg::cau_ctrl_t   lc;
  logic signed [RW-1:0] qd_re, qd_im, v_re, v_im;
  logic                 hi_re, lo_re, hi_im, lo_im;
  logic signed [W-1:0]  res_re_nxt, res_im_nxt;
  logic [1:0]           status_nxt;

  assign lc = ch_ctrl[W];

  always_comb begin
    // An out-of-range quotient becomes a value just past the word so that it clamps.
    if (lc.ovf_re) begin
      qd_re = lc.neg_re ? -BIG : BIG;
    end else begin
      qd_re = lc.neg_re ? -$signed(RW'(ch_q_re[W])) : $signed(RW'(ch_q_re[W]));
    end
    if (lc.ovf_im) begin
      qd_im = lc.neg_im ? -BIG : BIG;
    end else begin
      qd_im = lc.neg_im ? -$signed(RW'(ch_q_im[W])) : $signed(RW'(ch_q_im[W]));
    end
    if (lc.div_zero) begin
      v_re = '0;
      v_im = '0;
    end else if (lc.is_div) begin
      v_re = qd_re;
      v_im = qd_im;
    end else begin
      v_re = ch_sre[W];
      v_im = ch_sim[W];
    end
    hi_re = v_re > HI_LIM;
    lo_re = v_re < LO_LIM;
    hi_im = v_im > HI_LIM;
    lo_im = v_im < LO_LIM;
    res_re_nxt = hi_re ? HI_LIM[W-1:0] : (lo_re ? LO_LIM[W-1:0] : v_re[W-1:0]);
    res_im_nxt = hi_im ? HI_LIM[W-1:0] : (lo_im ? LO_LIM[W-1:0] : v_im[W-1:0]);
    if (lc.div_zero) begin
      status_nxt = cau_pkg::ST_DZ;
    end else if (hi_re || lo_re || hi_im || lo_im) begin
      status_nxt = cau_pkg::ST_SAT;
    end else begin
      status_nxt = cau_pkg::ST_OK;
    end
  end

  // Hold the result while the consumer stalls; load the next one otherwise.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ch_valid[W];
    end
    if (adv) begin
      out_res_re         <= res_re_nxt;
      out_res_im         <= res_im_nxt;
      out_operands_equal <= lc.eq;
      out_status         <= status_nxt;
    end
  end

  // A zero divisor must leave a zero result.
  `CAU_ASSERT_IMPL(a_dz_zero, clk, rst_n, out_valid && (out_status == cau_pkg::ST_DZ), (out_res_re == '0) && (out_res_im == '0), "division by zero with nonzero result")
  // A saturated status needs at least one part pinned at a word limit.
  `CAU_ASSERT_IMPL(a_sat_limit, clk, rst_n, out_valid && (out_status == cau_pkg::ST_SAT), (out_res_re == HI_LIM[W-1:0]) || (out_res_re == LO_LIM[W-1:0]) || (out_res_im == HI_LIM[W-1:0]) || (out_res_im == LO_LIM[W-1:0]), "saturation flagged without clamped part")
  // Reset empties the output register.
  `CAU_ASSERT_NEXT(a_rst_empty, clk, !rst_n, !out_valid, "output valid after reset")

endmodule

@@ sim/complex_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;

  localparam int W  = 32;
  localparam int FB = 16;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = 1 <<< FB;

  typedef struct {
    logic [2:0]          opcode;
    logic signed [W-1:0] a_re, a_im, b_re, b_im;
  } operands_t;

  typedef struct {
    logic signed [W-1:0] re, im;
    logic                eq;
    logic [1:0]          status;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = cau_pkg::OP_ADD;
  logic signed [W-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] out_res_re, out_res_im;
  logic out_operands_equal;
  logic [1:0] out_status;

  operands_t    pending_ops[$];
  cplx_result_t expected_results[$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  complex_arithmetic_unit #(.DATA_WIDTH(W), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_operands_equal(out_operands_equal), .out_status(out_status)
  );

  // Clamp a wide intermediate to the word range, noting any clipping.
  function automatic logic signed [W-1:0] clamp_word(logic signed [127:0] x, ref bit clipped);
    if (x > WMAX) begin
      clipped = 1'b1;
      return WMAX;
    end
    if (x < WMIN) begin
      clipped = 1'b1;
      return WMIN;
    end
    return x[W-1:0];
  endfunction

  // Full-precision complex arithmetic; 128 bits hold every intermediate.
  function automatic cplx_result_t compute_cplx(operands_t t);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    bit dz, clipped;
    cplx_result_t r;
    ar = t.a_re; ai = t.a_im; br = t.b_re; bi = t.b_im;
    re = 0; im = 0; dz = 0; clipped = 0;
    case (t.opcode)
      cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
      cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
      cau_pkg::OP_MUL: begin
        re = (ar * br - ai * bi) >>> FB;
        im = (ar * bi + ai * br) >>> FB;
      end
      cau_pkg::OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) dz = 1;
        else begin
          re = ((ar * br + ai * bi) <<< FB) / den;
          im = ((ai * br - ar * bi) <<< FB) / den;
        end
      end
      cau_pkg::OP_CONJ: begin re = ar; im = -ai; end
      cau_pkg::OP_MOD: re = (ar * ar + ai * ai) >>> FB;
      cau_pkg::OP_SCALE: begin re = (ar * br) >>> FB; im = (ai * br) >>> FB; end
      default: begin
        if (br == 0) dz = 1;
        else begin
          re = (ar <<< FB) / br;
          im = (ai <<< FB) / br;
        end
      end
    endcase
    r.re = clamp_word(re, clipped);
    r.im = clamp_word(im, clipped);
    r.eq = (t.a_re == t.b_re) && (t.a_im == t.b_im);
    r.status = dz ? cau_pkg::ST_DZ : (clipped ? cau_pkg::ST_SAT : cau_pkg::ST_OK);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Driver: advance only once the current transaction has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(compute_cplx('{in_opcode, in_a_re, in_a_im, in_b_re, in_b_im}));
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          operands_t t;
          t = pending_ops.pop_front();
          in_opcode <= t.opcode;
          in_a_re <= t.a_re;
          in_a_im <= t.a_im;
          in_b_re <= t.b_re;
          in_b_im <= t.b_im;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected", out_res_re, '0);
        end else begin
          cplx_result_t e;
          e = expected_results.pop_front();
          if (out_res_re !== e.re) report_mismatch("res_re", out_res_re, e.re);
          if (out_res_im !== e.im) report_mismatch("res_im", out_res_im, e.im);
          if (out_operands_equal !== e.eq)
            report_mismatch("operands_equal", W'(out_operands_equal), W'(e.eq));
          if (out_status !== e.status)
            report_mismatch("status", W'(out_status), W'(e.status));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Bias towards the corners: extremes, small Q16.16 values and raw noise.
  function automatic logic signed [W-1:0] pick_word();
    case ($urandom_range(9))
      0: return WMAX;
      1: return WMIN;
      2: return '0;
      3: return $urandom_range(1) ? ONE : -ONE;
      4, 5: return $signed($urandom_range(16 * ONE)) - 8 * ONE;
      6: return $signed($urandom_range(255)) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] op, logic signed [W-1:0] ar, logic signed [W-1:0] ai,
                          logic signed [W-1:0] br, logic signed [W-1:0] bi);
    pending_ops.push_back('{op, ar, ai, br, bi});
  endtask

  task automatic queue_random(int count);
    operands_t t;
    repeat (count) begin
      t.opcode = 3'($urandom_range(7));
      t.a_re = pick_word();
      t.a_im = pick_word();
      t.b_re = pick_word();
      t.b_im = pick_word();
      // Make the equality flag and the zero divisor turn up often.
      case ($urandom_range(9))
        0: begin t.b_re = t.a_re; t.b_im = t.a_im; end
        1: begin t.b_re = '0; if ($urandom_range(1)) t.b_im = '0; end
        default: ;
      endcase
      pending_ops.push_back(t);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: every opcode, both divide-by-zero forms, clipping cases.
    queue_op(cau_pkg::OP_ADD, WMAX, WMAX, WMAX, WMAX);
    queue_op(cau_pkg::OP_ADD, WMIN, WMIN, WMIN, WMIN);
    queue_op(cau_pkg::OP_SUB, WMIN, WMAX, WMAX, WMIN);
    queue_op(cau_pkg::OP_SUB, ONE, ONE, ONE, ONE);
    queue_op(cau_pkg::OP_MUL, WMIN, WMIN, WMIN, WMIN);
    queue_op(cau_pkg::OP_MUL, -1, ONE, 1, -ONE);
    queue_op(cau_pkg::OP_DIV, ONE, ONE, '0, '0);
    queue_op(cau_pkg::OP_DIV, WMAX, WMIN, 1, '0);
    queue_op(cau_pkg::OP_DIV, -ONE, 3 * ONE, ONE, -ONE);
    queue_op(cau_pkg::OP_DIV, WMIN, WMIN, WMIN, WMIN);
    queue_op(cau_pkg::OP_CONJ, WMAX, WMIN, '0, '0);
    queue_op(cau_pkg::OP_CONJ, -5, 7, WMAX, WMIN);
    queue_op(cau_pkg::OP_MOD, WMIN, WMIN, 3, 4);
    queue_op(cau_pkg::OP_MOD, 3 * ONE, -4 * ONE, '0, '0);
    queue_op(cau_pkg::OP_SCALE, WMAX, WMIN, WMAX, ONE);
    queue_op(cau_pkg::OP_SCALE, -3, 3, -ONE, '0);
    queue_op(cau_pkg::OP_DIVR, ONE, -ONE, '0, ONE);
    queue_op(cau_pkg::OP_DIVR, WMAX, WMIN, 1, '0);
    queue_op(cau_pkg::OP_DIVR, -7 * ONE, 7, -2 * ONE, WMAX);
    queue_op(cau_pkg::OP_DIVR, WMIN, WMAX, -1, WMIN);
    wait (pending_ops.size() == 0);

    // Idle phases: none, sender gaps, receiver stalls, then both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 30 : 0;
      stall_pct     = (phase == 2) ? 79 : (phase == 3) ? 30 : 0;
      queue_random(400);
      wait (pending_ops.size() == 0);
    end

    // Drain, then allow the pipeline depth to pass.
    wait (!in_valid && expected_results.size() == 0);
    repeat (2 * W + 8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
